// ===== rtl/core/weighted_correlation_accumulator_unit_defines.svh =====
// Assertion macros for the weighted correlation accumulator RTL.
// No dependencies; expects clk and rst_n in the scope of each use.
`ifndef WEIGHTED_CORRELATION_ACCUMULATOR_UNIT_DEFINES_SVH
`define WEIGHTED_CORRELATION_ACCUMULATOR_UNIT_DEFINES_SVH

`ifndef NO_ASSERTIONS
// Same-cycle implication, checked at every rising edge outside reset.
`define WCA_ASSERT_IMPLIES(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle implication violated");
// Next-cycle implication, checked at every rising edge outside reset.
`define WCA_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle implication violated");
`else
`define WCA_ASSERT_IMPLIES(label, ante, cons)
`define WCA_ASSERT_NEXT(label, ante, cons)
`endif

`endif

// ===== rtl/core/wca_pkg.sv =====
// Shared types and constants for the weighted correlation accumulator.
// No dependencies; imported by every module of the block.
package wca_pkg;

    localparam int STEP_W     = 5;
    localparam int ALU_W      = 32;
    localparam int TERM_W     = 25;
    localparam int SCORE_W    = 40;
    localparam int COUNT_W    = 11;

    localparam logic [STEP_W-1:0] MAC_STEPS  = 5'd5;
    localparam logic [STEP_W-1:0] SQRT_STEPS = 5'd28;
    localparam logic [STEP_W-1:0] DIV_STEPS  = 5'd17;

    localparam logic [16:0]         CORR_ONE    = 17'd32768;
    localparam logic [6:0]          CORR_SCALE  = 7'd100;
    localparam logic [39:0]         ROUND_HALF  = 40'd16384;
    localparam logic signed [15:0]  OFFSET_RESET = 16'sd29491;

    localparam logic signed [SCORE_W-1:0] SUM_MAX = 40'sh7F_FFFF_FFFF;
    localparam logic signed [SCORE_W-1:0] SUM_MIN = 40'sh80_0000_0000;

    typedef struct packed {
        logic [3:0]  first_a;
        logic [3:0]  first_c;
        logic [3:0]  first_g;
        logic [3:0]  first_t;
        logic [3:0]  first_pad;
        logic [3:0]  second_a;
        logic [3:0]  second_c;
        logic [3:0]  second_g;
        logic [3:0]  second_t;
        logic [3:0]  second_pad;
        logic [15:0] row_weight;
        logic        last_row;
    } in_item_t;

    typedef struct packed {
        logic signed [SCORE_W-1:0] total_score;
        logic [COUNT_W-1:0]        valid_rows;
    } out_item_t;

    // Request from the correlation core to the accumulator.
    typedef struct packed {
        logic                     valid;
        logic                     last;
        logic                     counted;
        logic signed [TERM_W-1:0] term;
    } acc_cmd_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MAC,
        S_PROD,
        S_SQRT,
        S_DINIT,
        S_DIV,
        S_CORR,
        S_SCALE,
        S_MUL,
        S_TERM,
        S_ACC
    } corr_state_t;

endpackage

// ===== rtl/core/wca_cmpsub.sv =====
// Shared 32-bit compare-subtract unit for the square root and division steps.
// Depends on wca_pkg.
module wca_cmpsub
    import wca_pkg::*;
(
    input  logic [ALU_W-1:0] a,
    input  logic [ALU_W-1:0] b,
    output logic             ge,
    output logic [ALU_W-1:0] diff
);

    logic [ALU_W:0] sub_wide;

    // Borrow out of the subtraction doubles as the compare result.
    assign sub_wide = {1'b0, a} - {1'b0, b};
    assign ge       = ~sub_wide[ALU_W];
    assign diff     = sub_wide[ALU_W-1:0];

endmodule

// ===== rtl/core/wca_corr_core.sv =====
// Correlation sequencer: row statistics, bit-serial square root and division,
// weighted term. Depends on wca_pkg, wca_cmpsub and the assertion macro header.
`include "weighted_correlation_accumulator_unit_defines.svh"

module wca_corr_core
    import wca_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  in_item_t           in_data,
    input  logic signed [15:0] corr_offset,
    output acc_cmd_t           cmd,
    input  logic               cmd_ready
);

    corr_state_t        state_reg, state_next;
    logic [STEP_W-1:0]  step_reg, step_next;
    logic               cmd_valid;

    logic [3:0]         x1_reg [5];
    logic [3:0]         x2_reg [5];
    logic [6:0]         s1_reg, s2_reg;
    logic [15:0]        weight_reg;
    logic               last_reg;
    logic signed [15:0] num_reg;
    logic [12:0]        den1_reg, den2_reg;
    logic [55:0]        v_reg;
    logic [29:0]        rem_reg;
    logic [27:0]        root_reg;
    logic [16:0]        quot_reg;
    logic [16:0]        dmag_reg;
    logic               neg_reg;
    logic [23:0]        m1_reg;
    logic [39:0]        m2_reg;
    logic signed [TERM_W-1:0] term_reg;
    logic               counted_reg;

    logic [6:0]         s1_in, s2_in;
    logic signed [8:0]  d1, d2;
    logic signed [17:0] p12, sq1, sq2;
    logic               den_zero;
    logic [25:0]        prod;
    logic [15:0]        nmag;
    logic [43:0]        dividend;
    logic [16:0]        q_clamp;
    logic signed [17:0] corr, corr_diff;
    logic [39:0]        m2_round;
    logic signed [TERM_W-1:0] tmag_s;

    logic [ALU_W-1:0]   alu_a, alu_b, alu_diff;
    logic               alu_ge;

    wca_cmpsub u_cmpsub (
        .a    (alu_a),
        .b    (alu_b),
        .ge   (alu_ge),
        .diff (alu_diff)
    );

    assign s1_in = 7'(in_data.first_a) + 7'(in_data.first_c) + 7'(in_data.first_g)
                 + 7'(in_data.first_t) + 7'(in_data.first_pad);
    assign s2_in = 7'(in_data.second_a) + 7'(in_data.second_c) + 7'(in_data.second_g)
                 + 7'(in_data.second_t) + 7'(in_data.second_pad);

    // Deviation scaled by five: 5*x - sum.
    assign d1  = signed'(9'(x1_reg[0]) * 9'd5 - 9'(s1_reg));
    assign d2  = signed'(9'(x2_reg[0]) * 9'd5 - 9'(s2_reg));
    assign p12 = 18'(d1) * 18'(d2);
    assign sq1 = 18'(d1) * 18'(d1);
    assign sq2 = 18'(d2) * 18'(d2);

    assign den_zero = (den1_reg == '0) || (den2_reg == '0);
    assign prod     = 26'(den1_reg) * 26'(den2_reg);

    assign nmag     = num_reg[15] ? 16'(-num_reg) : 16'(num_reg);
    // Rounding half of the root fits under the shifted numerator, so no add.
    assign dividend = {1'b0, nmag[12:0], 3'b000, root_reg[27:1]};

    assign q_clamp   = (quot_reg > CORR_ONE) ? CORR_ONE : quot_reg;
    assign corr      = num_reg[15] ? -signed'({1'b0, q_clamp}) : signed'({1'b0, q_clamp});
    assign corr_diff = corr - 18'(corr_offset);

    assign m2_round = m2_reg + ROUND_HALF;
    assign tmag_s   = signed'(m2_round[39:15]);

    // Operand select for the shared unit.
    always_comb
    begin
        if (state_reg == S_DIV)
        begin
            alu_a = {2'b00, rem_reg[28:0], quot_reg[16]};
            alu_b = {4'b0000, root_reg};
        end
        else
        begin
            alu_a = {rem_reg, v_reg[55:54]};
            alu_b = {2'b00, root_reg, 2'b01};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        in_ready   = 1'b0;
        cmd_valid  = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    state_next = S_MAC;
                    step_next  = MAC_STEPS - 5'd1;
                end
            end
            S_MAC:
            begin
                step_next = step_reg - 5'd1;
                if (step_reg == '0)
                    state_next = S_PROD;
            end
            S_PROD:
            begin
                state_next = den_zero ? S_ACC : S_SQRT;
                step_next  = SQRT_STEPS - 5'd1;
            end
            S_SQRT:
            begin
                step_next = step_reg - 5'd1;
                if (step_reg == '0)
                    state_next = S_DINIT;
            end
            S_DINIT:
            begin
                state_next = S_DIV;
                step_next  = DIV_STEPS - 5'd1;
            end
            S_DIV:
            begin
                step_next = step_reg - 5'd1;
                if (step_reg == '0)
                    state_next = S_CORR;
            end
            S_CORR:  state_next = S_SCALE;
            S_SCALE: state_next = S_MUL;
            S_MUL:   state_next = S_TERM;
            S_TERM:  state_next = S_ACC;
            S_ACC:
            begin
                cmd_valid = 1'b1;
                if (cmd_ready)
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    x1_reg[0]  <= in_data.first_a;
                    x1_reg[1]  <= in_data.first_c;
                    x1_reg[2]  <= in_data.first_g;
                    x1_reg[3]  <= in_data.first_t;
                    x1_reg[4]  <= in_data.first_pad;
                    x2_reg[0]  <= in_data.second_a;
                    x2_reg[1]  <= in_data.second_c;
                    x2_reg[2]  <= in_data.second_g;
                    x2_reg[3]  <= in_data.second_t;
                    x2_reg[4]  <= in_data.second_pad;
                    s1_reg     <= s1_in;
                    s2_reg     <= s2_in;
                    weight_reg <= in_data.row_weight;
                    last_reg   <= in_data.last_row;
                    num_reg    <= '0;
                    den1_reg   <= '0;
                    den2_reg   <= '0;
                end
            end
            S_MAC:
            begin
                // Advance the count vectors one entry per cycle.
                for (int i = 0; i < 4; i++)
                begin
                    x1_reg[i] <= x1_reg[i+1];
                    x2_reg[i] <= x2_reg[i+1];
                end
                num_reg  <= num_reg + 16'(p12);
                den1_reg <= den1_reg + 13'(sq1);
                den2_reg <= den2_reg + 13'(sq2);
            end
            S_PROD:
            begin
                v_reg       <= {prod, 30'd0};
                rem_reg     <= '0;
                root_reg    <= '0;
                term_reg    <= '0;
                counted_reg <= ~den_zero;
            end
            S_SQRT:
            begin
                rem_reg  <= alu_ge ? alu_diff[29:0] : alu_a[29:0];
                root_reg <= {root_reg[26:0], alu_ge};
                v_reg    <= v_reg << 2;
            end
            S_DINIT:
            begin
                rem_reg  <= 30'(dividend[43:17]);
                quot_reg <= dividend[16:0];
            end
            S_DIV:
            begin
                rem_reg  <= alu_ge ? alu_diff[29:0] : alu_a[29:0];
                quot_reg <= {quot_reg[15:0], alu_ge};
            end
            S_CORR:
            begin
                dmag_reg <= corr_diff[17] ? 17'(-corr_diff) : 17'(corr_diff);
                neg_reg  <= corr_diff[17];
            end
            S_SCALE: m1_reg <= 24'(dmag_reg) * 24'(CORR_SCALE);
            S_MUL:   m2_reg <= 40'(m1_reg) * 40'(weight_reg);
            S_TERM:  term_reg <= neg_reg ? -tmag_s : tmag_s;
            S_ACC:   ;
            default: ;
        endcase
    end

    assign cmd = '{valid: cmd_valid, last: last_reg, counted: counted_reg, term: term_reg};

    `WCA_ASSERT_IMPLIES(a_sqrt_rem_bound, state_reg == S_SQRT, rem_reg <= (30'(root_reg) << 1))
    `WCA_ASSERT_IMPLIES(a_div_rem_bound, state_reg == S_DIV, rem_reg < 30'(root_reg))
    `WCA_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready)

endmodule

// ===== rtl/core/wca_score_acc.sv =====
// Saturating score sum, row counter and result register.
// Depends on wca_pkg and the assertion macro header.
`include "weighted_correlation_accumulator_unit_defines.svh"

module wca_score_acc
    import wca_pkg::*;
#(
    parameter int MAX_ROWS = 1024
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  acc_cmd_t  cmd,
    output logic      cmd_ready,
    output logic      out_valid,
    input  logic      out_ready,
    output out_item_t out_data
);

    localparam int CountCapInt = (MAX_ROWS < 2047) ? MAX_ROWS : 2047;
    localparam logic [COUNT_W-1:0] CountCap = COUNT_W'(CountCapInt);

    logic signed [SCORE_W-1:0] sum_reg;
    logic [COUNT_W-1:0]        count_reg;
    logic                      out_valid_reg;
    out_item_t                 out_data_reg;

    logic signed [SCORE_W:0]   sum_wide;
    logic signed [SCORE_W-1:0] sum_new;
    logic [COUNT_W-1:0]        count_new;
    logic                      take;

    // A last row waits only while the previous result is still held.
    assign cmd_ready = ~cmd.last | ~out_valid_reg | out_ready;
    assign take      = cmd.valid & cmd_ready;

    assign sum_wide = {sum_reg[SCORE_W-1], sum_reg} + (SCORE_W+1)'(cmd.term);

    always_comb
    begin
        if (sum_wide[SCORE_W] != sum_wide[SCORE_W-1])
            sum_new = sum_wide[SCORE_W] ? SUM_MIN : SUM_MAX;
        else
            sum_new = sum_wide[SCORE_W-1:0];
        if (cmd.counted && (count_reg < CountCap))
            count_new = count_reg + COUNT_W'(1);
        else
            count_new = count_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg       <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (take)
            begin
                if (cmd.last)
                begin
                    sum_reg   <= '0;
                    count_reg <= '0;
                end
                else
                begin
                    sum_reg   <= sum_new;
                    count_reg <= count_new;
                end
            end
            if (take && cmd.last)
                out_valid_reg <= 1'b1;
            else if (out_valid_reg && out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take && cmd.last)
            out_data_reg <= '{total_score: sum_new, valid_rows: count_new};
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    `WCA_ASSERT_IMPLIES(a_count_cap, 1'b1, count_reg <= CountCap)
    `WCA_ASSERT_NEXT(a_clear_on_last, take && cmd.last, sum_reg == '0 && count_reg == '0 && out_valid_reg)
    `WCA_ASSERT_NEXT(a_out_hold, out_valid_reg && !out_ready, out_valid_reg && $stable(out_data_reg))

endmodule

// ===== rtl/core/weighted_correlation_accumulator_unit.sv =====
// Top level of the weighted correlation accumulator.
// Depends on wca_pkg, wca_corr_core and wca_score_acc.
//
// Each accepted request is one row: two five-entry count vectors, a Q8.8 weight
// and a last-row flag. The block forms the Pearson correlation of the two
// vectors from exact integer sums (deviations scaled by five), subtracts the
// programmable offset (cfg_data, signed Q1.15, 0.9 after reset) and adds
// 100*(corr-offset)*weight in Q8 to a 40-bit saturating sum, counting the row.
// Rows where either vector is constant add nothing and are not counted. A row
// flagged last produces one result (sum and count, the row itself included)
// and clears both. The sequencer works on one row at a time: the 28-step square
// root and 17-step division, skipped for a row with a constant vector, share
// one 32-bit compare-subtract unit one result bit per cycle, with the row
// statistics before them and a short multiply chain after. in_ready is high
// only while the sequencer is idle. A finished result sits in an output
// register, so the next rows are taken while it waits; only a later last row
// holds at its final step until that result is taken. Write cfg_data only
// while the block is idle.

module weighted_correlation_accumulator_unit
    import wca_pkg::*;
#(
    parameter int MAX_ROWS = 1024
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  in_item_t           in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output out_item_t          out_data,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic signed [15:0] cfg_data
);

    logic signed [15:0] offset_reg;
    acc_cmd_t           cmd;
    logic               cmd_ready;

    // Configuration writes are always taken.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            offset_reg <= OFFSET_RESET;
        else if (cfg_valid)
            offset_reg <= cfg_data;
    end

    // Sequencer: statistics, root, quotient and the weighted term of one row.
    wca_corr_core u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .in_data     (in_data),
        .corr_offset (offset_reg),
        .cmd         (cmd),
        .cmd_ready   (cmd_ready)
    );

    // Running sum, row count and the result register.
    wca_score_acc #(
        .MAX_ROWS (MAX_ROWS)
    ) u_acc (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .cmd_ready (cmd_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule
